// ===== rtl/fbfl_pkg.sv =====
// fbfl_pkg: shared types and constants for the fixed block free list allocator
// no dependencies; imported by fbfl_csr, fbfl_engine and the top level core

package fbfl_pkg;

   localparam int NUM_BLOCKS = 256;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int LINK_W     = IDX_W + 1;
   localparam int BLOCKS_W   = 9;
   localparam int PAYLOAD_W  = 16;
   localparam int HEADER_W   = 8;
   localparam int SUM_W      = PAYLOAD_W + 1;
   localparam int OFFSET_W   = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(NUM_BLOCKS);

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_RECYCLED  = 2'd2;
   localparam logic [1:0] STATUS_REFUSED   = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 2'd2;

   localparam logic [BLOCKS_W-1:0]  BLOCKS_RESET  = 9'd256;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 16'd0;
   localparam logic [HEADER_W-1:0]  HEADER_RESET  = 8'd32;

   typedef struct packed {
      logic       kind;
      logic [7:0] free_index;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [7:0]          block_index;
      logic [OFFSET_W-1:0] byte_offset;
   } rsp_type;

   typedef struct packed {
      logic [BLOCKS_W-1:0]  blocks_in_use;
      logic [PAYLOAD_W-1:0] payload_bytes;
      logic [HEADER_W-1:0]  header_bytes;
   } cfg_type;

   // one word of the link memory
   typedef struct packed {
      logic              in_use;
      logic [LINK_W-1:0] link;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// ===== rtl/fbfl_ram.sv =====
// fbfl_ram: generic single write port, single read port ram with registered read
// no dependencies

module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fbfl_csr.sv =====
// fbfl_csr: configuration registers of the allocator
// depends on fbfl_pkg

module fbfl_csr import fbfl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_BLOCKS:  cfg_in.blocks_in_use = csr_wdata[BLOCKS_W-1:0];
            CSR_PAYLOAD: cfg_in.payload_bytes = csr_wdata[PAYLOAD_W-1:0];
            CSR_HEADER:  cfg_in.header_bytes  = csr_wdata[HEADER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blocks_in_use <= BLOCKS_RESET;
         cfg_ff.payload_bytes <= PAYLOAD_RESET;
         cfg_ff.header_bytes  <= HEADER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/fbfl_engine.sv =====
// fbfl_engine: free list engine, head and fresh counters, link memory read-modify-write
// depends on fbfl_pkg and fbfl_ram

module fbfl_engine import fbfl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   logic                  accept;
   logic                  exec_en;
   logic                  kind_ff;
   logic [IDX_W-1:0]      fidx_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [LINK_W-1:0]     fresh_ff, fresh_in;
   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [ENTRY_W-1:0]    rd_word;
   entry_type             rd_entry;
   entry_type             wr_entry;
   logic                  wr_en;
   logic [LINK_W-1:0]     pool_n;
   logic [LINK_W-1:0]     next_head;
   logic                  head_empty;
   logic                  entry_used;
   logic                  got_ok;
   logic                  free_ok;
   logic [IDX_W-1:0]      got;
   logic [SUM_W-1:0]      stride;
   logic [OFFSET_W-1:0]   product;
   logic [OFFSET_W-1:0]   offset;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy    = 1'b0;
      exec_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_EXEC: begin
            busy    = 1'b1;
            exec_en = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   assign accept     = start & ~busy;
   assign head_empty = head_ff[LINK_W-1];

   // an allocate reads the entry it is about to hand out, a free reads its own entry
   assign rd_addr = (req_data.kind == KIND_FREE) ? req_data.free_index[IDX_W-1:0] :
                    head_empty ? fresh_ff[IDX_W-1:0] : head_ff[IDX_W-1:0];

   fbfl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry   = entry_type'(rd_word);
   assign entry_used = valid_ff[addr_ff] & rd_entry.in_use;
   assign pool_n     = (cfg.blocks_in_use > BLOCKS_W'(NUM_BLOCKS)) ? EMPTY_MARK :
                       LINK_W'(cfg.blocks_in_use);
   assign next_head  = (rd_entry.link > EMPTY_MARK) ? EMPTY_MARK : rd_entry.link;

   always_comb begin
      head_in  = head_ff;
      fresh_in = fresh_ff;
      got_ok   = 1'b0;
      free_ok  = 1'b0;
      got      = addr_ff;
      wr_en    = 1'b0;
      wr_entry = rd_entry;
      if (exec_en) begin
         if (kind_ff == KIND_ALLOC) begin
            if (!head_empty) begin
               got_ok  = 1'b1;
               head_in = next_head;
            end else if (fresh_ff < pool_n) begin
               got_ok   = 1'b1;
               fresh_in = fresh_ff + LINK_W'(1);
            end
            wr_en           = got_ok;
            wr_entry.in_use = 1'b1;
         end else begin
            free_ok = ({1'b0, fidx_ff} < pool_n) & entry_used;
            if (free_ok) begin
               head_in = {1'b0, fidx_ff};
            end
            wr_en           = free_ok;
            wr_entry.in_use = 1'b0;
            wr_entry.link   = head_ff;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[addr_ff] = 1'b1;
      end
   end

   assign stride  = {1'b0, cfg.payload_bytes} + SUM_W'(cfg.header_bytes);
   assign product = OFFSET_W'(got) * OFFSET_W'(stride);
   assign offset  = product + OFFSET_W'(cfg.header_bytes);

   always_comb begin
      rsp_in             = '0;
      rsp_in.block_index = '0;
      if (kind_ff == KIND_ALLOC) begin
         if (got_ok) begin
            rsp_in.status      = STATUS_ALLOCATED;
            rsp_in.block_index = 8'(got);
            rsp_in.byte_offset = offset;
         end else begin
            rsp_in.status = STATUS_EMPTY;
         end
      end else begin
         rsp_in.status = free_ok ? STATUS_RECYCLED : STATUS_REFUSED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= EMPTY_MARK;
         fresh_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= exec_en;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_data.kind;
         fidx_ff <= req_data.free_index[IDX_W-1:0];
         addr_ff <= rd_addr;
      end
      if (exec_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= EMPTY_MARK)
      else $error("free list head beyond empty marker");

   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= EMPTY_MARK)
      else $error("fresh block counter beyond pool size");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid_ff)
      else $error("no result two cycles after accepted transaction");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while engine still busy");

   a_write_on_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> exec_en)
      else $error("link memory written outside execute cycle");
`endif

endmodule

// ===== rtl/fixed_block_free_list_allocator_core.sv =====
// fixed_block_free_list_allocator_core: top level of the fixed block pool allocator
// depends on fbfl_pkg, fbfl_csr, fbfl_engine (and through it fbfl_ram)
//
// usage:
//   request channel: drive req_data and raise start; the transaction is taken at
//   a rising edge with start high and busy low. kind allocate pops the free list
//   head (or the next untouched block), kind free pushes an in-use block back.
//   result channel: rsp_valid is high for exactly one cycle with rsp_data; the
//   receiver cannot stall and must take the result in that cycle.
//   csr channel: csr_valid/csr_ready with csr_index (0 block count, 1 payload
//   bytes, 2 header bytes) and csr_wdata; write only while the block is idle.
// timing:
//   an accepted transaction executes in ST_EXEC, where busy is high for one
//   cycle and no new transaction is taken; its result is then registered into
//   rsp_valid and rsp_data. transactions are paced by the link memory read-
//   modify-write: entry read on accept, then head, in-use bit and link updated.
// reset:
//   synchronous; free list empty, fresh counter zero, all in-use flags cleared
//   at once by per-entry valid bits (no clearing pass), csr defaults restored.

module fixed_block_free_list_allocator_core import fbfl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   fbfl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fbfl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
